FILE: rtl/fsp_pkg.sv
// shared constants, result codes and controller/datapath interface types
`timescale 1ns / 1ps

package fsp_pkg;

	// payload store
	localparam int BUFFER_DEPTH = 64;
	localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

	// field widths
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;
	localparam int INDEX_W = 6;
	localparam int TICK_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 32;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

	// reset values of the registers
	localparam logic [BYTE_W-1:0] START_RST   = 8'h7E;
	localparam logic [BYTE_W-1:0] END_RST     = 8'h7F;
	localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd1000;

	// result kinds
	localparam logic [KIND_W-1:0] K_BYTE    = 3'd0;
	localparam logic [KIND_W-1:0] K_EMPTY   = 3'd1;
	localparam logic [KIND_W-1:0] K_BADEND  = 3'd2;
	localparam logic [KIND_W-1:0] K_OVER    = 3'd3;
	localparam logic [KIND_W-1:0] K_TIMEOUT = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic              load_id;
		logic              load_len;
		logic              store_byte;
		logic              clr_ticks;
		logic              inc_ticks;
		logic              clear_frame;
		logic              emit;
		logic [KIND_W-1:0] emit_kind;
		logic              drain_start;
		logic              mem_rd;
		logic              emit_byte;
		logic              drain_next;
	} fsp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_hit;
		logic end_hit;
		logic len_zero;
		logic room;
		logic fill_done;
		logic tick_over;
		logic count_zero;
		logic drain_last;
		logic out_free;
	} fsp_stat_t;

endpackage

FILE: rtl/framed_serial_packet_receiver.sv
// top level of the framed serial packet receiver
`timescale 1ns / 1ps

// Parses a serial byte stream framed as start code, device id, length,
// payload and end code. Each input transaction is either a received byte
// (s_tuser low, byte in s_tdata) or one time tick (s_tuser high). Payload
// bytes are kept in a 64-entry store; a correct end code releases them as a
// run of byte results with m_tlast on the final one, or one empty-frame
// result for a zero-length frame. A wrong end code, a payload byte that does
// not fit the store, or more than idle_timeout ticks without a byte while a
// frame is open each give a single error result and return to idle. Bytes
// and ticks are taken one per cycle as long as the result register is free
// or being emptied in the same cycle. After a good end code the store is
// drained one payload byte at a time (store read, then result register
// load), and input is held off for the whole drain, output stalls included.
// Configuration writes take effect at once and should only be made while
// no frame is in flight.
module framed_serial_packet_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// input transactions
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] action: 0 byte, 1 tick
	// result transactions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] device_id, [15:8] frame_length,
	                               // [23:16] data_byte, [29:24] byte_index
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast,   // last result of a run
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index, // 0 start_code, 1 end_code, 2 idle_timeout
	input  logic [15:0] cfg_data
);
	import fsp_pkg::*;

	fsp_cmd_t  cmd;
	fsp_stat_t stat;

	// protocol phase and drain sequencing
	fsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// registers, payload store and result register
	fsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

`ifndef SYNTHESIS
	// input is only taken when a result produced by it has somewhere to go
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken while result register is blocked");

	// error and empty-frame results are single results
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != K_BYTE)) |-> m_tlast)
		else $error("non-byte result without last");

	// only byte results carry payload and index
	a_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != K_BYTE)) |-> (m_tdata[29:16] == '0))
		else $error("non-byte result carries payload");

	// a byte result that is not last is followed by more of the run, not new input
	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && (m_tuser == K_BYTE) && !m_tlast) |-> !s_tready)
		else $error("input taken in the middle of a payload run");
`endif

endmodule

FILE: rtl/fsp_ctrl.sv
// frame parser controller: protocol phase and payload drain sequencing
`timescale 1ns / 1ps

module fsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	input  fsp_pkg::fsp_stat_t stat,
	output fsp_pkg::fsp_cmd_t  cmd
);
	import fsp_pkg::*;

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_RD  = 2'd1;
	localparam logic [1:0] ST_WR  = 2'd2;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ID   = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_END  = 3'd4;

	logic [1:0] state_q, state_d;
	logic [2:0] phase_q, phase_d;
	logic       accept;

	assign s_tready = (state_q == ST_ACC) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		cmd.emit_kind = K_BYTE;
		unique case (state_q)
			ST_ACC: begin
				if (accept) begin
					if (s_tuser) begin
						// time tick
						if (phase_q != PH_IDLE) begin
							if (stat.tick_over) begin
								cmd.emit        = 1'b1;
								cmd.emit_kind   = K_TIMEOUT;
								cmd.clear_frame = 1'b1;
								phase_d         = PH_IDLE;
							end else begin
								cmd.inc_ticks = 1'b1;
							end
						end
					end else begin
						cmd.clr_ticks = 1'b1;
						unique case (phase_q)
							PH_ID: begin
								cmd.load_id = 1'b1;
								phase_d     = PH_LEN;
							end
							PH_LEN: begin
								cmd.load_len = 1'b1;
								phase_d      = stat.len_zero ? PH_END : PH_DATA;
							end
							PH_DATA: begin
								if (stat.room) begin
									cmd.store_byte = 1'b1;
									if (stat.fill_done) begin
										phase_d = PH_END;
									end
								end else begin
									cmd.emit        = 1'b1;
									cmd.emit_kind   = K_OVER;
									cmd.clear_frame = 1'b1;
									phase_d         = PH_IDLE;
								end
							end
							PH_END: begin
								phase_d = PH_IDLE;
								if (stat.end_hit && !stat.count_zero) begin
									// frame state is cleared after the drain
									cmd.drain_start = 1'b1;
									state_d         = ST_RD;
								end else begin
									cmd.emit        = 1'b1;
									cmd.emit_kind   = stat.end_hit ? K_EMPTY : K_BADEND;
									cmd.clear_frame = 1'b1;
								end
							end
							default: begin
								phase_d = stat.start_hit ? PH_ID : PH_IDLE;
							end
						endcase
					end
				end
			end
			ST_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_WR;
			end
			ST_WR: begin
				if (stat.out_free) begin
					cmd.emit_byte = 1'b1;
					if (stat.drain_last) begin
						cmd.clear_frame = 1'b1;
						state_d         = ST_ACC;
					end else begin
						cmd.drain_next = 1'b1;
						state_d        = ST_RD;
					end
				end
			end
			default: begin
				state_d = ST_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

FILE: rtl/fsp_dp.sv
// frame parser datapath: registers, frame fields, payload store, result register
`timescale 1ns / 1ps

module fsp_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [fsp_pkg::BYTE_W-1:0]          s_tdata,
	input  logic                                cfg_we,
	input  logic [fsp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fsp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  fsp_pkg::fsp_cmd_t                   cmd,
	output fsp_pkg::fsp_stat_t                  stat,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fsp_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [fsp_pkg::KIND_W-1:0]          m_tuser,
	output logic                                m_tlast
);
	import fsp_pkg::*;

	logic [BYTE_W-1:0]  start_q, end_q;
	logic [TICK_W-1:0]  timeout_q, ticks_q;
	logic [BYTE_W-1:0]  id_q, len_q;
	logic [CNT_W-1:0]   count_q, idx_q;
	logic [BYTE_W-1:0]  mem [2**ADDR_W];
	logic [BYTE_W-1:0]  rdata_q;

	logic               valid_q;
	logic [KIND_W-1:0]  kind_q;
	logic [BYTE_W-1:0]  out_id_q, out_len_q, out_data_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic               last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= START_RST;
			end_q     <= END_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START:   start_q   <= cfg_data[BYTE_W-1:0];
				REG_END:     end_q     <= cfg_data[BYTE_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// frame fields, idle counter, drain index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q    <= '0;
			len_q   <= '0;
			count_q <= '0;
			ticks_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.clear_frame) begin
				id_q    <= '0;
				len_q   <= '0;
				count_q <= '0;
				ticks_q <= '0;
			end else begin
				if (cmd.load_id) begin
					id_q <= s_tdata;
				end
				if (cmd.load_len) begin
					len_q   <= s_tdata;
					count_q <= '0;
				end
				if (cmd.store_byte) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (cmd.clr_ticks) begin
					ticks_q <= '0;
				end else if (cmd.inc_ticks) begin
					ticks_q <= ticks_q + TICK_W'(1);
				end
			end
			if (cmd.drain_start) begin
				idx_q <= '0;
			end else if (cmd.drain_next) begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end
	end

	// payload store
	always_ff @(posedge clk) begin
		if (cmd.store_byte) begin
			mem[count_q[ADDR_W-1:0]] <= s_tdata;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	assign stat.start_hit  = (s_tdata == start_q);
	assign stat.end_hit    = (s_tdata == end_q);
	assign stat.len_zero   = (s_tdata == '0);
	assign stat.room       = (BYTE_W'(count_q) < len_q) && (count_q < CNT_W'(BUFFER_DEPTH));
	assign stat.fill_done  = (BYTE_W'(count_q) + BYTE_W'(1)) >= len_q;
	assign stat.tick_over  = (ticks_q >= timeout_q);
	assign stat.count_zero = (count_q == '0);
	assign stat.drain_last = ((idx_q + CNT_W'(1)) == count_q);
	assign stat.out_free   = !valid_q || m_tready;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_byte) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q     <= cmd.emit_kind;
			out_id_q   <= id_q;
			out_len_q  <= len_q;
			out_data_q <= '0;
			out_idx_q  <= '0;
			last_q     <= 1'b1;
		end else if (cmd.emit_byte) begin
			kind_q     <= K_BYTE;
			out_id_q   <= id_q;
			out_len_q  <= len_q;
			out_data_q <= rdata_q;
			out_idx_q  <= INDEX_W'(idx_q);
			last_q     <= stat.drain_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {2'b00, out_idx_q, out_data_q, out_len_q, out_id_q};

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the framed serial packet receiver
`timescale 1ns / 1ps

module testbench;
	import fsp_pkg::*;

	// cycles with no transaction on either side before the run is abandoned
	localparam int WATCHDOG_LIMIT = 4000;
	// quiet cycles after the last expected result before a register write or the end
	localparam int SETTLE_CYCLES  = 16;

	typedef enum logic [2:0] {
		PH_IDLE, PH_ID, PH_LEN, PH_DATA, PH_END
	} rx_phase_t;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [BYTE_W-1:0]  id;
		logic [BYTE_W-1:0]  len;
		logic [BYTE_W-1:0]  data;
		logic [INDEX_W-1:0] index;
		logic               last;
	} rx_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;  // [7:0] rx_byte
	logic        s_tuser   = 1'b0; // [0] action
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;   // [7:0] id, [15:8] length, [23:16] data, [29:24] index
	logic [2:0]  m_tuser;   // [2:0] kind
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	framed_serial_packet_receiver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// parser shadow state and register copies
	rx_phase_t         model_phase;
	logic [BYTE_W-1:0] model_id;
	logic [BYTE_W-1:0] model_len;
	int                model_fill;
	logic [BYTE_W-1:0] model_store [BUFFER_DEPTH];
	logic [TICK_W-1:0] model_ticks;
	logic [BYTE_W-1:0] cfg_start_code;
	logic [BYTE_W-1:0] cfg_end_code;
	logic [TICK_W-1:0] cfg_idle_timeout;

	rx_result_t pending_results [$];
	rx_result_t want;

	int  errors       = 0;
	int  items_sent   = 0;
	int  results_seen = 0;
	int  kind_seen [8];
	int  stuck_cycles = 0;
	int  burst_left   = 0;
	int  stall_left   = 0;
	bit  tx_gaps_on   = 1'b1;
	bit  rx_stall_on  = 1'b1;

	function automatic void clear_frame();
		model_phase = PH_IDLE;
		model_id    = '0;
		model_len   = '0;
		model_fill  = 0;
		model_ticks = '0;
	endfunction

	function automatic void push_result(input logic [KIND_W-1:0] kind,
		input logic [BYTE_W-1:0] data, input logic [INDEX_W-1:0] index, input logic last);
		rx_result_t r;
		r.kind  = kind;
		r.id    = model_id;
		r.len   = model_len;
		r.data  = data;
		r.index = index;
		r.last  = last;
		pending_results.push_back(r);
	endfunction

	// advance the shadow parser by one accepted transaction
	function automatic void parse_item(input logic act, input logic [BYTE_W-1:0] b);
		if (act) begin
			// ticks only count while a frame is open
			if (model_phase == PH_IDLE)
				return;
			if ({1'b0, model_ticks} + 17'd1 > {1'b0, cfg_idle_timeout}) begin
				push_result(K_TIMEOUT, '0, '0, 1'b1);
				clear_frame();
			end else begin
				model_ticks = model_ticks + TICK_W'(1);
			end
			return;
		end
		model_ticks = '0;
		case (model_phase)
			PH_ID: begin
				model_id    = b;
				model_phase = PH_LEN;
			end
			PH_LEN: begin
				model_len   = b;
				model_fill  = 0;
				model_phase = (b != 0) ? PH_DATA : PH_END;
			end
			PH_DATA: begin
				if (model_fill < model_len && model_fill < BUFFER_DEPTH) begin
					model_store[model_fill] = b;
					model_fill++;
					if (model_fill >= model_len)
						model_phase = PH_END;
				end else begin
					// byte that no longer fits the store
					push_result(K_OVER, '0, '0, 1'b1);
					clear_frame();
				end
			end
			PH_END: begin
				if (b == cfg_end_code) begin
					if (model_fill == 0)
						push_result(K_EMPTY, '0, '0, 1'b1);
					else
						for (int i = 0; i < model_fill; i++)
							push_result(K_BYTE, model_store[i], INDEX_W'(i),
								i == model_fill - 1);
				end else begin
					push_result(K_BADEND, '0, '0, 1'b1);
				end
				clear_frame();
			end
			default: begin
				// anything but the start code is dropped while idle
				if (b == cfg_start_code)
					model_phase = PH_ID;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
		end
	endfunction

	// one input transaction; called and returning at a falling edge
	task automatic send_item(input logic act, input logic [BYTE_W-1:0] b);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		parse_item(act, b);
		items_sent++;
		@(negedge clk);
		// sender works in bursts with gaps in between
		if (tx_gaps_on) begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(0, 11);
			end else begin
				burst_left--;
			end
		end
	endtask

	// now and then a run of ticks, sometimes enough to time out
	task automatic send_ticks(input int tick_max);
		if (tick_max > 0 && $urandom_range(0, 99) < 15)
			repeat ($urandom_range(1, tick_max)) send_item(1'b1, 8'($urandom));
	endtask

	// frame with random payload and a good or bad end code; lengths past the store overflow
	task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len,
		input bit good_end, input int tick_max);
		int n;
		logic [BYTE_W-1:0] term;
		n = (len > BUFFER_DEPTH) ? BUFFER_DEPTH + 1 : len;
		send_item(1'b0, cfg_start_code);
		send_ticks(tick_max);
		send_item(1'b0, id);
		send_ticks(tick_max);
		send_item(1'b0, len);
		for (int i = 0; i < n; i++) begin
			send_ticks(tick_max);
			send_item(1'b0, 8'($urandom));
		end
		if (len <= BUFFER_DEPTH) begin
			term = good_end ? cfg_end_code : cfg_end_code ^ 8'($urandom_range(1, 255));
			send_ticks(tick_max);
			send_item(1'b0, term);
		end
	endtask

	// drop valid, wait for every expected result, then let the block settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// feed bytes until the parser is back in idle
	task automatic close_frame();
		while (model_phase != PH_IDLE) send_item(1'b0, 8'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_START:   cfg_start_code   = val[BYTE_W-1:0];
			REG_END:     cfg_end_code     = val[BYTE_W-1:0];
			REG_TIMEOUT: cfg_idle_timeout = val;
			default: ;
		endcase
	endtask

	// reset register values: dropped bytes, idle ticks, empty, short and bad frames
	task automatic test_basic_frames();
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'hFF);
		send_item(1'b0, START_RST);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b0, END_RST);
		send_item(1'b0, START_RST);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h01);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, END_RST);
		send_item(1'b0, START_RST);
		send_item(1'b0, 8'h5A);
		send_item(1'b0, 8'h02);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h80);
		send_item(1'b0, END_RST);
		send_item(1'b0, START_RST);
		send_item(1'b0, 8'h01);
		send_item(1'b0, 8'h00);
		send_item(1'b0, START_RST);
	endtask

	// timeout register set to one, byte clearing the tick count, timeout lowered mid-frame
	task automatic test_timeouts();
		write_reg(REG_START, 16'h0000);
		write_reg(REG_END, 16'h00FF);
		write_reg(REG_TIMEOUT, 16'd1);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'h00);
		send_item(1'b0, 8'h33);
		send_item(1'b1, 8'hFF);
		send_item(1'b1, 8'h00);
		write_reg(REG_TIMEOUT, 16'd5);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h10);
		repeat (3) send_item(1'b1, 8'h00);
		// lower the limit while the frame is still open
		write_reg(REG_TIMEOUT, 16'd2);
		send_item(1'b1, 8'h00);
	endtask

	// full store up to the top index, then a frame that overflows it
	task automatic test_store_limits();
		write_reg(REG_START, 16'h00FF);
		write_reg(REG_END, 16'h0000);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		send_frame(8'hC3, 8'(BUFFER_DEPTH), 1'b1, 0);
		send_frame(8'h3C, 8'($urandom_range(BUFFER_DEPTH + 1, 255)), 1'b1, 0);
	endtask

	// mostly well-formed frames with random content, plus noise and broken frames
	task automatic test_random_traffic();
		int quota;
		int r;
		int tick_max;
		logic [BYTE_W-1:0] len_pick;
		for (int p = 0; p < 4; p++) begin
			close_frame();
			tx_gaps_on  = (p != 2);
			rx_stall_on = (p != 3);
			if (p == 3) begin
				write_reg(REG_START, {8'h00, START_RST});
				write_reg(REG_END, {8'h00, END_RST});
				write_reg(REG_TIMEOUT, 16'($urandom_range(2, 6)));
			end else begin
				write_reg(REG_START, 16'($urandom_range(0, 255)));
				write_reg(REG_END, 16'($urandom_range(0, 255)));
				write_reg(REG_TIMEOUT, (p == 1) ? 16'hFFFF : 16'($urandom_range(1, 12)));
			end
			tick_max = (cfg_idle_timeout <= 16) ? int'(cfg_idle_timeout) + 1 : 0;
			quota = items_sent + 16;
			while (items_sent < quota) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					repeat ($urandom_range(1, 3))
						send_item(1'($urandom_range(0, 1)), 8'($urandom));
				end else if (r < 16) begin
					// frame cut off early, left to time out or be swallowed
					send_item(1'b0, cfg_start_code);
					repeat ($urandom_range(0, 3)) send_item(1'b0, 8'($urandom));
					send_ticks(tick_max);
				end else begin
					r = $urandom_range(0, 99);
					if (r < 60)      len_pick = 8'($urandom_range(0, 6));
					else if (r < 85) len_pick = 8'($urandom_range(7, 20));
					else if (r < 96) len_pick = 8'($urandom_range(21, BUFFER_DEPTH));
					else             len_pick = 8'($urandom_range(BUFFER_DEPTH + 1, 255));
					send_frame(8'($urandom), len_pick, $urandom_range(0, 99) < 85, tick_max);
				end
			end
		end
		close_frame();
	endtask

	// receiver: random stalls of random length, or always ready
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_stall_on && $urandom_range(0, 9) < 3) begin
			stall_left = $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			kind_seen[m_tuser]++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual kind %0d tdata %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_tuser));
				check_field("device_id", 32'(want.id), 32'(m_tdata[7:0]));
				check_field("frame_length", 32'(want.len), 32'(m_tdata[15:8]));
				check_field("data_byte", 32'(want.data), 32'(m_tdata[23:16]));
				check_field("byte_index", 32'(want.index), 32'(m_tdata[29:24]));
				check_field("last", 32'(want.last), 32'(m_tlast));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding",
				$time, stuck_cycles, pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		cfg_start_code   = START_RST;
		cfg_end_code     = END_RST;
		cfg_idle_timeout = TIMEOUT_RST;
		clear_frame();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_frames();
		test_timeouts();
		test_store_limits();
		test_random_traffic();

		wait_drained();
		$display("covered %0d input transactions, %0d results, %0d errors found",
			items_sent, results_seen, errors);
		$display("results by kind: byte %0d, empty %0d, bad end %0d, overflow %0d, timeout %0d",
			kind_seen[K_BYTE], kind_seen[K_EMPTY], kind_seen[K_BADEND], kind_seen[K_OVER],
			kind_seen[K_TIMEOUT]);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
